// File: src/gtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_pkg
// shared types and constants of the gated target lock tracker
// ----------------------------------------------------------------------------
package gtl_pkg;

   // configuration register indexes
   localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CFG_GATE_DISTANCE = 2'd1;
   localparam logic [1:0] CFG_MIN_AREA      = 2'd2;

   localparam int CFG_INDEX_BITS = 2;
   localparam int CFG_DATA_BITS  = 24;

   localparam int IMAGE_WIDTH_BITS   = 13;
   localparam int HALF_WIDTH_BITS    = 12;
   localparam int GATE_DISTANCE_BITS = 12;
   localparam int MIN_AREA_BITS      = 24;

   localparam logic [12:0] IMAGE_WIDTH_RESET   = 13'd640;
   localparam logic [11:0] GATE_DISTANCE_RESET = 12'd80;
   localparam logic [23:0] MIN_AREA_RESET      = 24'd20;

   // entries between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic counting;
      logic last;
   } item_flags_type;

endpackage

// File: src/gated_target_lock_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_target_lock_tracker_top
// tracks one locked target over frames of candidate boxes
//
// req_ channel: one candidate box per item, req_last_box on the frame's final
// item; an item with req_box_present low adds nothing but can close a frame.
// rsp_ channel: one item per frame, issued for the item with req_last_box set,
// giving found, the locked box and its center (all zero when nothing found).
// csr_ port: single-cycle writes of image width, gate distance and min area;
// the user must write only while the block is idle; the block does not enforce it.
// throughput: one item per cycle while req_ready is high; the front classifies
// the box (area gate, center, distance to image center) in the accept cycle, a
// two-entry queue feeds the back, which updates the lock as it takes each item.
// a frame result passes through the queue entry and then the back's result
// register after its last item is accepted, and a stalled rsp_ can delay it.
// a stalled rsp_ receiver holds the result; the back keeps taking items until
// the next last item, then the queue fills and req_ready drops.
// reset: synchronous; registers return to 640 / 80 / 20, lock cleared.
// ----------------------------------------------------------------------------
module gated_target_lock_tracker_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_box_present,
   input  logic [COORD_BITS-1:0]                 req_box_x,
   input  logic [COORD_BITS-1:0]                 req_box_y,
   input  logic [COORD_BITS:0]                   req_box_w,
   input  logic [COORD_BITS:0]                   req_box_h,
   input  logic                                  req_last_box,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic [COORD_BITS-1:0]                 rsp_out_x,
   output logic [COORD_BITS-1:0]                 rsp_out_y,
   output logic [COORD_BITS:0]                   rsp_out_w,
   output logic [COORD_BITS:0]                   rsp_out_h,
   output logic [COORD_BITS:0]                   rsp_center_x,
   output logic [COORD_BITS:0]                   rsp_center_y,
   input  logic                                  csr_write_enable,
   input  logic [gtl_pkg::CFG_INDEX_BITS-1:0]    csr_index,
   input  logic [gtl_pkg::CFG_DATA_BITS-1:0]     csr_write_data
);

   localparam int DIST_BITS = (COORD_BITS + 1 > gtl_pkg::HALF_WIDTH_BITS) ?
                              COORD_BITS + 1 : gtl_pkg::HALF_WIDTH_BITS;
   localparam int FLAG_BITS = $bits(gtl_pkg::item_flags_type);
   localparam int Q_WIDTH   = FLAG_BITS + 2 * COORD_BITS + 3 * (COORD_BITS + 1) + DIST_BITS;

   logic [gtl_pkg::IMAGE_WIDTH_BITS-1:0]   image_width_ff, image_width_in;
   logic [gtl_pkg::GATE_DISTANCE_BITS-1:0] gate_distance_ff, gate_distance_in;
   logic [gtl_pkg::MIN_AREA_BITS-1:0]      min_area_ff, min_area_in;

   gtl_pkg::item_flags_type front_flags;
   logic [COORD_BITS:0]     front_cx;
   logic [DIST_BITS-1:0]    front_dist;
   logic [Q_WIDTH-1:0]      q_in_data;
   logic [Q_WIDTH-1:0]      q_out_data;
   logic                    q_out_valid;
   logic                    q_out_ready;

   gtl_pkg::item_flags_type back_flags;
   logic [COORD_BITS-1:0]   back_x;
   logic [COORD_BITS-1:0]   back_y;
   logic [COORD_BITS:0]     back_w;
   logic [COORD_BITS:0]     back_h;
   logic [COORD_BITS:0]     back_cx;
   logic [DIST_BITS-1:0]    back_dist;

   always_comb begin
      image_width_in   = image_width_ff;
      gate_distance_in = gate_distance_ff;
      min_area_in      = min_area_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gtl_pkg::CFG_IMAGE_WIDTH: begin
               image_width_in = csr_write_data[gtl_pkg::IMAGE_WIDTH_BITS-1:0];
            end
            gtl_pkg::CFG_GATE_DISTANCE: begin
               gate_distance_in = csr_write_data[gtl_pkg::GATE_DISTANCE_BITS-1:0];
            end
            gtl_pkg::CFG_MIN_AREA: begin
               min_area_in = csr_write_data[gtl_pkg::MIN_AREA_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= gtl_pkg::IMAGE_WIDTH_RESET;
         gate_distance_ff <= gtl_pkg::GATE_DISTANCE_RESET;
         min_area_ff      <= gtl_pkg::MIN_AREA_RESET;
      end else begin
         image_width_ff   <= image_width_in;
         gate_distance_ff <= gate_distance_in;
         min_area_ff      <= min_area_in;
      end
   end

   gtl_front #(
      .COORD_BITS (COORD_BITS),
      .DIST_BITS  (DIST_BITS)
   ) u_front (
      .box_present (req_box_present),
      .box_x       (req_box_x),
      .box_w       (req_box_w),
      .box_h       (req_box_h),
      .last_box    (req_last_box),
      .image_width (image_width_ff),
      .min_area    (min_area_ff),
      .flags       (front_flags),
      .center_x    (front_cx),
      .distance    (front_dist)
   );

   assign q_in_data = {front_flags, req_box_x, req_box_y, req_box_w, req_box_h,
                       front_cx, front_dist};

   gtl_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (gtl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   assign {back_flags, back_x, back_y, back_w, back_h, back_cx, back_dist} = q_out_data;

   gtl_back #(
      .COORD_BITS (COORD_BITS),
      .DIST_BITS  (DIST_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (q_out_valid),
      .item_ready    (q_out_ready),
      .item_flags    (back_flags),
      .item_x        (back_x),
      .item_y        (back_y),
      .item_w        (back_w),
      .item_h        (back_h),
      .item_cx       (back_cx),
      .item_dist     (back_dist),
      .gate_distance (gate_distance_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_w     (rsp_out_w),
      .rsp_out_h     (rsp_out_h),
      .rsp_center_x  (rsp_center_x),
      .rsp_center_y  (rsp_center_y)
   );

   // empty frame gives an all-zero item
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_out_x == '0 && rsp_out_y == '0 &&
         rsp_out_w == '0 && rsp_out_h == '0 && rsp_center_x == '0 && rsp_center_y == '0))
      else $error("empty frame item carries nonzero fields");

   // a locked box passed the area gate, so it cannot be degenerate
   a_found_size : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_out_w != '0 && rsp_out_h != '0))
      else $error("locked box has zero width or height");

   // centers agree with the reported box
   a_found_center : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_center_x == ({1'b0, rsp_out_x} + {1'b0, rsp_out_w[COORD_BITS:1]}) &&
          rsp_center_y == ({1'b0, rsp_out_y} + {1'b0, rsp_out_h[COORD_BITS:1]})))
      else $error("center does not match locked box");

endmodule

// File: src/gtl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_front
// classifies an incoming box: area gate, horizontal center, image center distance
// ----------------------------------------------------------------------------
module gtl_front #(
   parameter int COORD_BITS = 12,
   parameter int DIST_BITS  = 13
) (
   input  logic                                      box_present,
   input  logic [COORD_BITS-1:0]                     box_x,
   input  logic [COORD_BITS:0]                       box_w,
   input  logic [COORD_BITS:0]                       box_h,
   input  logic                                      last_box,
   input  logic [gtl_pkg::IMAGE_WIDTH_BITS-1:0]      image_width,
   input  logic [gtl_pkg::MIN_AREA_BITS-1:0]         min_area,
   output gtl_pkg::item_flags_type                   flags,
   output logic [COORD_BITS:0]                       center_x,
   output logic [DIST_BITS-1:0]                      distance
);

   localparam int AREA_BITS = 2 * COORD_BITS + 2;
   localparam int CMP_BITS  = (AREA_BITS > gtl_pkg::MIN_AREA_BITS) ?
                              AREA_BITS : gtl_pkg::MIN_AREA_BITS;

   logic [AREA_BITS-1:0]                     area;
   logic [gtl_pkg::HALF_WIDTH_BITS-1:0]      half_width;
   logic [DIST_BITS-1:0]                     cx_ext;
   logic [DIST_BITS-1:0]                     half_ext;

   assign area       = {{(COORD_BITS+1){1'b0}}, box_w} * {{(COORD_BITS+1){1'b0}}, box_h};
   assign half_width = image_width[gtl_pkg::IMAGE_WIDTH_BITS-1:1];
   assign center_x   = {1'b0, box_x} + {1'b0, box_w[COORD_BITS:1]};

   assign cx_ext   = DIST_BITS'(center_x);
   assign half_ext = DIST_BITS'(half_width);
   assign distance = (cx_ext > half_ext) ? (cx_ext - half_ext) : (half_ext - cx_ext);

   assign flags.counting = box_present && (CMP_BITS'(area) > CMP_BITS'(min_area));
   assign flags.last     = last_box;

endmodule

// File: src/gtl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_queue
// small register queue between the classifying front and the tracking back
// ----------------------------------------------------------------------------
module gtl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = gtl_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: src/gtl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_back
// lock keeping, nearest-to-center search and per-frame result register
// ----------------------------------------------------------------------------
module gtl_back #(
   parameter int COORD_BITS = 12,
   parameter int DIST_BITS  = 13
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       item_valid,
   output logic                                       item_ready,
   input  gtl_pkg::item_flags_type                    item_flags,
   input  logic [COORD_BITS-1:0]                      item_x,
   input  logic [COORD_BITS-1:0]                      item_y,
   input  logic [COORD_BITS:0]                        item_w,
   input  logic [COORD_BITS:0]                        item_h,
   input  logic [COORD_BITS:0]                        item_cx,
   input  logic [DIST_BITS-1:0]                       item_dist,
   input  logic [gtl_pkg::GATE_DISTANCE_BITS-1:0]     gate_distance,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic                                       rsp_found,
   output logic [COORD_BITS-1:0]                      rsp_out_x,
   output logic [COORD_BITS-1:0]                      rsp_out_y,
   output logic [COORD_BITS:0]                        rsp_out_w,
   output logic [COORD_BITS:0]                        rsp_out_h,
   output logic [COORD_BITS:0]                        rsp_center_x,
   output logic [COORD_BITS:0]                        rsp_center_y
);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS:0]   w;
      logic [COORD_BITS:0]   h;
   } box_type;

   localparam int EDGE_BITS = COORD_BITS + 2;

   logic                  lock_held_ff, lock_held_in;
   box_type               locked_box_ff, locked_box_in;
   logic [COORD_BITS:0]   locked_cx_ff, locked_cx_in;
   logic                  keep_found_ff, keep_found_in;
   box_type               keep_box_ff, keep_box_in;
   logic                  nearest_found_ff, nearest_found_in;
   box_type               nearest_box_ff, nearest_box_in;
   logic [DIST_BITS:0]    nearest_dist_ff, nearest_dist_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   box_type               rsp_box_ff, rsp_box_in;
   logic [COORD_BITS:0]   rsp_cx_ff, rsp_cx_in;
   logic [COORD_BITS:0]   rsp_cy_ff, rsp_cy_in;

   box_type               item_box;
   box_type               sel_box;
   logic                  pop;
   logic                  overlap;
   logic                  gate_hit;
   logic                  keep_hit;
   logic                  near_hit;
   logic [COORD_BITS:0]   gate_diff;
   logic [EDGE_BITS-1:0]  item_x_end, item_y_end, lock_x_end, lock_y_end;

   assign item_box   = '{x: item_x, y: item_y, w: item_w, h: item_h};
   assign item_ready = !(item_flags.last && rsp_valid_ff && !rsp_ready);
   assign pop        = item_valid && item_ready;

   // overlap: positive intersection on both axes
   assign item_x_end = {2'b00, item_box.x} + {1'b0, item_box.w};
   assign item_y_end = {2'b00, item_box.y} + {1'b0, item_box.h};
   assign lock_x_end = {2'b00, locked_box_ff.x} + {1'b0, locked_box_ff.w};
   assign lock_y_end = {2'b00, locked_box_ff.y} + {1'b0, locked_box_ff.h};
   assign overlap = (item_box.w != '0) && (locked_box_ff.w != '0) &&
                    (item_box.h != '0) && (locked_box_ff.h != '0) &&
                    ({2'b00, item_box.x} < lock_x_end) &&
                    ({2'b00, locked_box_ff.x} < item_x_end) &&
                    ({2'b00, item_box.y} < lock_y_end) &&
                    ({2'b00, locked_box_ff.y} < item_y_end);

   assign gate_diff = (item_cx > locked_cx_ff) ? (item_cx - locked_cx_ff) :
                                                 (locked_cx_ff - item_cx);
   assign gate_hit  = DIST_BITS'(gate_diff) < DIST_BITS'(gate_distance);

   assign keep_hit = item_flags.counting && lock_held_ff && !keep_found_ff &&
                     (overlap || gate_hit);
   assign near_hit = item_flags.counting && ({1'b0, item_dist} < nearest_dist_ff);

   always_comb begin
      lock_held_in     = lock_held_ff;
      locked_box_in    = locked_box_ff;
      locked_cx_in     = locked_cx_ff;
      keep_found_in    = keep_found_ff;
      keep_box_in      = keep_box_ff;
      nearest_found_in = nearest_found_ff;
      nearest_box_in   = nearest_box_ff;
      nearest_dist_in  = nearest_dist_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_found_in     = rsp_found_ff;
      rsp_box_in       = rsp_box_ff;
      rsp_cx_in        = rsp_cx_ff;
      rsp_cy_in        = rsp_cy_ff;
      sel_box          = nearest_box_ff;
      if (pop) begin
         if (keep_hit) begin
            keep_found_in = 1'b1;
            keep_box_in   = item_box;
         end
         if (near_hit) begin
            nearest_found_in = 1'b1;
            nearest_box_in   = item_box;
            nearest_dist_in  = {1'b0, item_dist};
         end
         if (item_flags.last) begin
            sel_box = (lock_held_ff && keep_found_in) ? keep_box_in : nearest_box_in;
            rsp_valid_in = 1'b1;
            if (nearest_found_in) begin
               lock_held_in  = 1'b1;
               locked_box_in = sel_box;
               locked_cx_in  = {1'b0, sel_box.x} + {1'b0, sel_box.w[COORD_BITS:1]};
               rsp_found_in  = 1'b1;
               rsp_box_in    = sel_box;
               rsp_cx_in     = {1'b0, sel_box.x} + {1'b0, sel_box.w[COORD_BITS:1]};
               rsp_cy_in     = {1'b0, sel_box.y} + {1'b0, sel_box.h[COORD_BITS:1]};
            end else begin
               lock_held_in = 1'b0;
               rsp_found_in = 1'b0;
               rsp_box_in   = '0;
               rsp_cx_in    = '0;
               rsp_cy_in    = '0;
            end
            // new frame
            keep_found_in    = 1'b0;
            nearest_found_in = 1'b0;
            nearest_dist_in  = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_held_ff     <= 1'b0;
         keep_found_ff    <= 1'b0;
         nearest_found_ff <= 1'b0;
         nearest_dist_ff  <= '1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         lock_held_ff     <= lock_held_in;
         keep_found_ff    <= keep_found_in;
         nearest_found_ff <= nearest_found_in;
         nearest_dist_ff  <= nearest_dist_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      locked_box_ff  <= locked_box_in;
      locked_cx_ff   <= locked_cx_in;
      keep_box_ff    <= keep_box_in;
      nearest_box_ff <= nearest_box_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_box_ff     <= rsp_box_in;
      rsp_cx_ff      <= rsp_cx_in;
      rsp_cy_ff      <= rsp_cy_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_out_x    = rsp_box_ff.x;
   assign rsp_out_y    = rsp_box_ff.y;
   assign rsp_out_w    = rsp_box_ff.w;
   assign rsp_out_h    = rsp_box_ff.h;
   assign rsp_center_x = rsp_cx_ff;
   assign rsp_center_y = rsp_cy_ff;

endmodule
